// File: sv/tslc_pkg.sv
// ----------------------------------------------------------------------------
// tslc_pkg
// Types and constants for the TTL set-associative lookup cache.
// ----------------------------------------------------------------------------
`default_nettype none

package tslc_pkg;

  localparam int unsigned ENTRIES_DEF = 4096;
  localparam int unsigned WAYS_DEF    = 4;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [31:0] TTL_RESET = 32'd10000;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_STORE  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic        [31:0] key;
    logic        [63:0] context_base;
    logic signed [31:0] context_count;
    logic        [63:0] store_value;
    logic        [31:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] found_value;
    logic        stored;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [63:0] base;
    logic [31:0] count;
    logic [63:0] data;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_WB
  } state_t;

endpackage

`default_nettype wire

// File: sv/ttl_set_assoc_lookup_cache.sv
// ----------------------------------------------------------------------------
// ttl_set_assoc_lookup_cache
// Set-associative lookup cache with time-to-live expiry and oldest-stamp
// replacement; one set per memory row.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  in_     | input     | in_valid / in_stall | tslc_pkg::req_t
//  out_    | output    | out_valid/out_stall | tslc_pkg::rsp_t
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_data: ttl_ticks
//
//  Each request passes through accept, hash multiply, set read from the
//  synchronous row memory, way compare and write-back, in that order.
//  The write-back waits while the output register holds an untaken result;
//  the next request is accepted as soon as the write-back is done.
//  After reset a clearing pass writes every row, all ENTRIES/WAYS of them
//  (1024 at defaults), with in_stall high; cfg writes are taken throughout.
//
`default_nettype none

module ttl_set_assoc_lookup_cache #(
  parameter int unsigned ENTRIES = tslc_pkg::ENTRIES_DEF,
  parameter int unsigned WAYS    = tslc_pkg::WAYS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire tslc_pkg::req_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output tslc_pkg::rsp_t       out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [31:0]     cfg_data
);

  import tslc_pkg::*;

  localparam int unsigned SETS  = ENTRIES / WAYS;
  localparam int unsigned IDX_W = $clog2(SETS);
  localparam int unsigned ENT_W = $clog2(ENTRIES);
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  state_t state_r, state_nxt;

  req_t              req_r;
  logic [31:0]       prod_r;
  logic [31:0]       hash;
  logic [IDX_W-1:0]  set_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic [31:0]       ttl_r;

  entry_t [WAYS-1:0] mem [SETS];
  entry_t [WAYS-1:0] rdata_r;
  entry_t [WAYS-1:0] wrow;
  logic [IDX_W-1:0]  waddr;

  logic              mem_re, mem_we, out_load, go;
  logic              wr_en_r, wr_en_nxt;
  logic [WAY_W-1:0]  pick_r, pick_nxt;
  rsp_t              res_r, res_nxt;
  logic              out_valid_r;
  rsp_t              out_data_r;

  assign cfg_ready = 1'b1;
  assign hash      = prod_r ^ (prod_r >> 16);
  assign go        = !out_valid_r || !out_stall;

  // --- configuration register ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ttl_r <= cfg_data;
    end
  end

  // --- next state ---
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == IDX_W'(SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_HASH;
      ST_HASH:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_WB;
      ST_WB:    if (go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // --- control outputs ---
  always_comb begin
    in_stall = 1'b1;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  in_stall = 1'b0;
      ST_READ:  mem_re = 1'b1;
      ST_WB: begin
        out_load = go;
        mem_we   = go && wr_en_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // --- request datapath ---
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req_r <= in_data;
    if (state_r == ST_HASH) prod_r <= req_r.key * HASH_MULT;
    if (state_r == ST_READ) set_r <= hash[ENT_W-1 -: IDX_W];
    if (state_r == ST_CMP) begin
      res_r   <= res_nxt;
      pick_r  <= pick_nxt;
      wr_en_r <= wr_en_nxt;
    end
  end

  // --- set memory ---
  always_comb begin
    wrow  = rdata_r;
    waddr = set_r;
    wrow[pick_r] = '{valid: 1'b1, key: req_r.key, base: req_r.context_base,
                     count: req_r.context_count, data: req_r.store_value,
                     stamp: req_r.now_ticks};
    if (state_r == ST_CLEAR) begin
      wrow  = '0;
      waddr = clr_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wrow;
    if (mem_re) rdata_r <= mem[hash[ENT_W-1 -: IDX_W]];
  end

  // --- way compare and replacement choice ---
  always_comb begin
    logic        req_ok, found, have_free;
    logic [31:0] min_stamp, age;
    logic [WAY_W-1:0] free_idx, min_idx;
    req_ok = (req_r.key != '0) && (req_r.context_base != '0) &&
             (req_r.context_count > 0);
    found     = 1'b0;
    have_free = 1'b0;
    free_idx  = '0;
    min_idx   = '0;
    min_stamp = rdata_r[0].stamp;
    res_nxt   = '0;
    for (int w = 0; w < int'(WAYS); w++) begin
      age = req_r.now_ticks - rdata_r[w].stamp;
      if (!found && rdata_r[w].valid && rdata_r[w].key == req_r.key &&
          rdata_r[w].base == req_r.context_base &&
          rdata_r[w].count == req_r.context_count &&
          rdata_r[w].data != '0 && rdata_r[w].stamp != '0 && age <= ttl_r) begin
        found               = 1'b1;
        res_nxt.found_value = rdata_r[w].data;
      end
      if (!have_free && (!rdata_r[w].valid || rdata_r[w].key == req_r.key)) begin
        have_free = 1'b1;
        free_idx  = WAY_W'(w);
      end
      if (rdata_r[w].stamp < min_stamp) begin
        min_stamp = rdata_r[w].stamp;
        min_idx   = WAY_W'(w);
      end
    end
    pick_nxt  = have_free ? free_idx : min_idx;
    wr_en_nxt = req_ok && (req_r.req_type == REQ_STORE) && (req_r.store_value != '0);
    res_nxt.stored = wr_en_nxt;
    if (!(req_ok && found && req_r.req_type == REQ_LOOKUP)) begin
      res_nxt.found_value = '0;
    end else begin
      res_nxt.hit = 1'b1;
    end
  end

  // --- output register ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --- assertions ---
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_WB))
    else $error("memory write outside clear or write-back");

  a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_HASH))
    else $error("accepted request did not start hashing");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.stored))
    else $error("result both hit and stored");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.found_value == '0))
    else $error("miss carries a nonzero value");

  a_no_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !out_load)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: sim/tb_ttl_set_assoc_lookup_cache.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ttl_set_assoc_lookup_cache
// Self-checking bench for the TTL lookup cache. Directed tests cover rejected
// requests, the expiry window, oldest-stamp replacement and the TTL extremes.
// Mixed random traffic over colliding keys follows. Every accepted request is
// run through a behavioral copy of the cache, and each response is compared
// against the oldest pending prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ttl_set_assoc_lookup_cache;
  import tslc_pkg::*;

  localparam int unsigned SET_MASK   = ENTRIES_DEF - WAYS_DEF;
  localparam int unsigned IDLE_LIMIT = 6000;
  localparam int unsigned KEY_POOL   = 16;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  req_t        in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  ttl_set_assoc_lookup_cache i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Behavioral copy of the cache contents and the TTL register
  bit          way_valid [ENTRIES_DEF];
  logic [31:0] way_key   [ENTRIES_DEF];
  logic [63:0] way_base  [ENTRIES_DEF];
  logic [31:0] way_count [ENTRIES_DEF];
  logic [63:0] way_data  [ENTRIES_DEF];
  logic [31:0] way_stamp [ENTRIES_DEF];
  logic [31:0] ttl_model = TTL_RESET;

  rsp_t        pending_rsp [$];
  int unsigned fail_cnt    = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle     = 1'b0;
  bit          in_held     = 1'b0;
  int unsigned stall_run   = 0;

  logic [31:0] key_pool   [KEY_POOL];
  logic [63:0] base_pool  [3];
  logic [31:0] count_pool [4];
  logic [31:0] clk_ticks  = 32'd1;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned set_of(logic [31:0] key);
    logic [31:0] h;
    h = key * HASH_MULT;
    h = h ^ (h >> 16);
    return h & SET_MASK;
  endfunction

  function automatic logic [31:0] next_in_set(int unsigned set_idx, logic [31:0] from);
    logic [31:0] k;
    k = from;
    while (k == 0 || set_of(k) != set_idx) k++;
    return k;
  endfunction

  // Apply one request to the cache copy and return its response
  function automatic rsp_t cache_access(req_t r);
    rsp_t        res;
    int unsigned b;
    int unsigned idx;
    int unsigned pick;
    logic [31:0] age;
    res = '0;
    if (r.key == 0 || r.context_base == 0 || r.context_count[31] || r.context_count == 0)
      return res;
    b = set_of(r.key);
    if (r.req_type == REQ_LOOKUP) begin
      for (int w = 0; w < WAYS_DEF; w++) begin
        idx = b + w;
        if (!way_valid[idx]) continue;
        age = r.now_ticks - way_stamp[idx];
        if (way_key[idx] == r.key && way_base[idx] == r.context_base &&
            way_count[idx] == r.context_count && way_data[idx] != 0 &&
            way_stamp[idx] != 0 && age <= ttl_model) begin
          res.hit         = 1'b1;
          res.found_value = way_data[idx];
          return res;
        end
      end
      return res;
    end
    if (r.store_value == 0) return res;
    pick = b;
    for (int w = 0; w < WAYS_DEF; w++) begin
      idx = b + w;
      if (!way_valid[idx] || way_key[idx] == r.key) begin
        pick = idx;
        break;
      end
      if (way_stamp[idx] < way_stamp[pick]) pick = idx;
    end
    way_valid[pick] = 1'b1;
    way_key[pick]   = r.key;
    way_base[pick]  = r.context_base;
    way_count[pick] = r.context_count;
    way_data[pick]  = r.store_value;
    way_stamp[pick] = r.now_ticks;
    res.stored      = 1'b1;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic req_t make_req(logic op, logic [31:0] key, logic [63:0] base,
                                    logic [31:0] count, logic [63:0] value,
                                    logic [31:0] now);
    req_t r;
    r.req_type      = op;
    r.key           = key;
    r.context_base  = base;
    r.context_count = count;
    r.store_value   = value;
    r.now_ticks     = now;
    return r;
  endfunction

  // Keep valid high straight into the next transfer when no gap follows
  task automatic send_req(input req_t r);
    int unsigned gap;
    if (!in_held) in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rsp.push_back(cache_access(r));
    gap     = pick_gap();
    in_held = (gap == 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
      @(posedge clk);
    end
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [31:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ttl_model = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_rejected_requests();
    send_req(make_req(REQ_STORE, 32'hFFFF_FFFF, '1, 32'h7FFF_FFFF, '1, 32'hFFFF_FFFF));
    send_req(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, '1, 32'h7FFF_FFFF, '0, 32'hFFFF_FFFF));
    send_req(make_req(REQ_STORE, 32'h0, '1, 32'd5, 64'd9, 32'd10));
    send_req(make_req(REQ_STORE, 32'h55, 64'h0, 32'd5, 64'd9, 32'd10));
    send_req(make_req(REQ_STORE, 32'h55, 64'd3, 32'h0, 64'd9, 32'd10));
    send_req(make_req(REQ_STORE, 32'h55, 64'd3, 32'h8000_0000, 64'd9, 32'd10));
    send_req(make_req(REQ_STORE, 32'h55, 64'd3, 32'd5, 64'h0, 32'd10));
    send_req(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF));
  endtask

  task automatic test_expiry_window();
    send_req(make_req(REQ_STORE, 32'hA5, 64'h1234, 32'd7, 64'hDEAD_BEEF, 32'd1000));
    send_req(make_req(REQ_LOOKUP, 32'hA5, 64'h1234, 32'd7, '0, 32'd11000));
    send_req(make_req(REQ_LOOKUP, 32'hA5, 64'h1234, 32'd7, '0, 32'd11001));
    send_req(make_req(REQ_LOOKUP, 32'hA5, 64'h1235, 32'd7, '0, 32'd1000));
    // age wraps through zero
    send_req(make_req(REQ_STORE, 32'hB6, 64'h77, 32'd1, 64'h1, 32'hFFFF_FFF0));
    send_req(make_req(REQ_LOOKUP, 32'hB6, 64'h77, 32'd1, '0, 32'd5));
    // a stamp of zero never hits
    send_req(make_req(REQ_STORE, 32'hC7, 64'h88, 32'd2, 64'h2, 32'd0));
    send_req(make_req(REQ_LOOKUP, 32'hC7, 64'h88, 32'd2, '0, 32'd0));
  endtask

  task automatic test_way_replacement();
    logic [31:0] k [5];
    int unsigned s;
    k[0] = 32'h1234;
    s    = set_of(k[0]);
    for (int i = 1; i < 5; i++) k[i] = next_in_set(s, k[i-1] + 1);
    send_req(make_req(REQ_STORE, k[0], 64'h9, 32'd3, 64'h100, 32'd300));
    send_req(make_req(REQ_STORE, k[1], 64'h9, 32'd3, 64'h101, 32'd200));
    send_req(make_req(REQ_STORE, k[2], 64'h9, 32'd3, 64'h102, 32'd400));
    send_req(make_req(REQ_STORE, k[3], 64'h9, 32'd3, 64'h103, 32'd200));
    // full set, tie on the oldest stamp
    send_req(make_req(REQ_STORE, k[4], 64'h9, 32'd3, 64'h104, 32'd500));
    send_req(make_req(REQ_STORE, k[1], 64'h9, 32'd3, 64'h105, 32'd600));
    send_req(make_req(REQ_LOOKUP, k[3], 64'h9, 32'd3, '0, 32'd600));
    send_req(make_req(REQ_STORE, k[0], 64'h9, 32'd3, 64'h106, 32'd700));
    send_req(make_req(REQ_LOOKUP, k[0], 64'h9, 32'd3, '0, 32'd700));
  endtask

  task automatic test_ttl_extremes();
    write_ttl(32'd0);
    send_req(make_req(REQ_STORE, 32'hD8, 64'h5, 32'd4, 64'h42, 32'd77));
    send_req(make_req(REQ_LOOKUP, 32'hD8, 64'h5, 32'd4, '0, 32'd77));
    send_req(make_req(REQ_LOOKUP, 32'hD8, 64'h5, 32'd4, '0, 32'd78));
    write_ttl(32'hFFFF_FFFF);
    send_req(make_req(REQ_LOOKUP, 32'hD8, 64'h5, 32'd4, '0, 32'd76));
  endtask

  task automatic fill_pools();
    int unsigned s;
    key_pool[0] = $urandom | 32'h1;
    s = set_of(key_pool[0]);
    for (int i = 1; i < 6; i++) key_pool[i] = next_in_set(s, key_pool[i-1] + 1);
    key_pool[6] = $urandom | 32'h1;
    s = set_of(key_pool[6]);
    for (int i = 7; i < 9; i++) key_pool[i] = next_in_set(s, key_pool[i-1] + 1);
    for (int i = 9; i < KEY_POOL; i++) key_pool[i] = $urandom | 32'h1;
    base_pool[0]  = '1;
    base_pool[1]  = {$urandom, $urandom} | 64'h1;
    base_pool[2]  = 64'h1;
    count_pool[0] = 32'd1;
    count_pool[1] = 32'h7FFF_FFFF;
    count_pool[2] = $urandom_range(1000, 2);
    count_pool[3] = ($urandom >> 1) | 32'h1;
  endtask

  task automatic run_traffic(input int unsigned n);
    req_t        r;
    int unsigned sel;
    int unsigned ki;
    int unsigned span;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 || $urandom_range(99) == 0) wait_drained();
      sel = $urandom_range(99);
      if (sel < 12) begin
        r.req_type      = 1'($urandom);
        r.key           = $urandom;
        r.context_base  = {$urandom, $urandom};
        r.context_count = $urandom;
        r.store_value   = {$urandom, $urandom};
        r.now_ticks     = $urandom;
      end else begin
        ki              = $urandom_range(KEY_POOL - 1);
        r.key           = key_pool[ki];
        r.req_type      = ($urandom_range(99) < 40) ? REQ_STORE : REQ_LOOKUP;
        r.context_base  = base_pool[ki % 3];
        r.context_count = count_pool[ki % 4];
        if ($urandom_range(9) == 0) begin
          r.context_base  = base_pool[$urandom_range(2)];
          r.context_count = count_pool[$urandom_range(3)];
        end
        r.store_value = ($urandom_range(19) == 0) ? 64'h0 : {$urandom, $urandom};
        // broken requests: the key or one context field spoiled
        if (sel < 17) begin
          case ($urandom_range(3))
            0:       r.key           = '0;
            1:       r.context_base  = '0;
            2:       r.context_count = '0;
            default: r.context_count = $urandom | 32'h8000_0000;
          endcase
        end
        if (r.req_type == REQ_STORE) begin
          span = ttl_model >> 3;
          if ($urandom_range(9) == 0) clk_ticks += $urandom_range(5, 1);
          else clk_ticks += $urandom_range(span, 0);
          r.now_ticks = clk_ticks;
        end else begin
          sel = $urandom_range(99);
          if (sel < 50)      r.now_ticks = clk_ticks + $urandom_range(ttl_model >> 2, 0);
          else if (sel < 75) r.now_ticks = clk_ticks + ttl_model + $urandom_range(2) - 1;
          else if (sel < 90) r.now_ticks = $urandom;
          else               r.now_ticks = clk_ticks - $urandom_range(8, 1);
        end
      end
      send_req(r);
    end
  endtask

  task automatic test_mixed_traffic();
    fill_pools();
    write_ttl(TTL_RESET);
    run_traffic(150);
    write_ttl(32'd0);
    run_traffic(120);
    write_ttl(32'hFFFF_FFFF);
    run_traffic(120);
    // no idle gaps on the input, no output stalls
    write_ttl(32'd50);
    no_idle = 1'b1;
    run_traffic(120);
    no_idle = 1'b0;
    write_ttl($urandom_range(100000, 200));
    run_traffic(120);
    write_ttl($urandom);
    run_traffic(120);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_rejected_requests();
    test_expiry_window();
    test_way_replacement();
    test_ttl_extremes();
    test_mixed_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
      stall_run <= pick_gap();
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected response: hit=%0b value=%h stored=%0b",
                   out_data.hit, out_data.found_value, out_data.stored);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.hit !== want.hit || out_data.found_value !== want.found_value ||
            out_data.stored !== want.stored) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: exp hit=%0b value=%h stored=%0b, got hit=%0b value=%h stored=%0b",
                     want.hit, want.found_value, want.stored,
                     out_data.hit, out_data.found_value, out_data.stored);
        end
      end
    end
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
